FILE: sv/bbrf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package bbrf_pkg;

   localparam int MAX_RADIUS  = 15;
   localparam int WIN_DEPTH   = 2 * MAX_RADIUS + 1;
   localparam int WIN_IDX_W   = $clog2(WIN_DEPTH);
   localparam int RAD_W       = 4;
   localparam int PIX_W       = 8;
   localparam int SUM_W       = $clog2(WIN_DEPTH * 255 + 1);
   localparam int MAX_WIDTH   = 4096;
   localparam int ROWS_LIMIT  = 4096;
   localparam int COL_W       = 12;
   localparam int ROW_W       = 12;
   localparam int REG_W       = 13;
   localparam int CSR_IDX_W   = 2;
   localparam int RECIP_SHIFT = 18;
   localparam int RECIP_W     = RECIP_SHIFT + 1;
   localparam int PROD_W      = SUM_W + RECIP_W;

   localparam logic [CSR_IDX_W-1:0] CSR_RADIUS    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_WIDTH = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_COUNT = 2'd2;

   localparam logic [RAD_W-1:0] RADIUS_RESET    = 4'd1;
   localparam logic [REG_W-1:0] ROW_WIDTH_RESET = 13'd640;
   localparam logic [REG_W-1:0] ROW_COUNT_RESET = 13'd480;

   typedef struct packed {
      logic             step;
      logic             fill;
      logic [PIX_W-1:0] px;
   } win_ctl_type;

   typedef struct packed {
      logic [SUM_W-1:0] sum;
      logic             last_row;
      logic             last_frame;
   } emit_type;

   // ceil(2^18 / (2r+1)), exact floor division for sums below 2^13
   function automatic logic [RECIP_W-1:0] recip_of(input logic [RAD_W-1:0] r);
      logic [RECIP_W-1:0] m;
      case (r)
         4'd0:    m = 19'd262144;
         4'd1:    m = 19'd87382;
         4'd2:    m = 19'd52429;
         4'd3:    m = 19'd37450;
         4'd4:    m = 19'd29128;
         4'd5:    m = 19'd23832;
         4'd6:    m = 19'd20165;
         4'd7:    m = 19'd17477;
         4'd8:    m = 19'd15421;
         4'd9:    m = 19'd13798;
         4'd10:   m = 19'd12484;
         4'd11:   m = 19'd11398;
         4'd12:   m = 19'd10486;
         4'd13:   m = 19'd9710;
         4'd14:   m = 19'd9040;
         4'd15:   m = 19'd8457;
         default: m = 19'd262144;
      endcase
      return m;
   endfunction

endpackage
`default_nettype wire

FILE: sv/bbrf_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module bbrf_cell (
   input  wire logic                      clock,
   input  wire logic                      step,
   input  wire logic                      fill,
   input  wire logic [bbrf_pkg::PIX_W-1:0] fill_px,
   input  wire logic [bbrf_pkg::PIX_W-1:0] left_px,
   input  wire logic                      is_tail,
   output logic      [bbrf_pkg::PIX_W-1:0] pix,
   output logic      [bbrf_pkg::PIX_W-1:0] tap
);

   logic [bbrf_pkg::PIX_W-1:0] pix_ff;
   logic [bbrf_pkg::PIX_W-1:0] pix_in;

   always_comb begin
      pix_in = pix_ff;
      if (step) begin
         pix_in = fill ? fill_px : left_px;
      end
   end

   always_ff @(posedge clock) begin
      pix_ff <= pix_in;
   end

   assign pix = pix_ff;
   assign tap = pix_ff & {bbrf_pkg::PIX_W{is_tail}};

endmodule
`default_nettype wire

FILE: sv/bbrf_window.sv
`timescale 1ns / 1ps
`default_nettype none
module bbrf_window (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire bbrf_pkg::win_ctl_type          ctl,
   input  wire logic      [bbrf_pkg::RAD_W-1:0] radius,
   output logic           [bbrf_pkg::SUM_W-1:0] sum_next
);

   logic [bbrf_pkg::PIX_W-1:0]     pix  [bbrf_pkg::WIN_DEPTH];
   logic [bbrf_pkg::PIX_W-1:0]     taps [bbrf_pkg::WIN_DEPTH];
   logic [bbrf_pkg::PIX_W-1:0]     drop;
   logic [bbrf_pkg::WIN_IDX_W-1:0] tail_idx;
   logic [bbrf_pkg::SUM_W-1:0]     sum_ff;
   logic [bbrf_pkg::SUM_W-1:0]     sum_in;
   logic [bbrf_pkg::SUM_W-1:0]     span;

   assign tail_idx = {radius, 1'b0};
   assign span     = bbrf_pkg::SUM_W'({radius, 1'b1});

   for (genvar i = 0; i < bbrf_pkg::WIN_DEPTH; i++) begin : g_cell
      logic [bbrf_pkg::PIX_W-1:0] left;
      if (i == 0) begin : g_head
         assign left = ctl.px;
      end else begin : g_body
         assign left = pix[i-1];
      end
      bbrf_cell u_cell (
         .clock   (clock),
         .step    (ctl.step),
         .fill    (ctl.fill),
         .fill_px (ctl.px),
         .left_px (left),
         .is_tail (tail_idx == bbrf_pkg::WIN_IDX_W'(i)),
         .pix     (pix[i]),
         .tap     (taps[i])
      );
   end

   always_comb begin
      drop = '0;
      for (int i = 0; i < bbrf_pkg::WIN_DEPTH; i++) begin
         drop = drop | taps[i];
      end
   end

   always_comb begin
      if (ctl.fill) begin
         sum_in = bbrf_pkg::SUM_W'(span * bbrf_pkg::SUM_W'(ctl.px));
      end else begin
         sum_in = sum_ff + bbrf_pkg::SUM_W'(ctl.px) - bbrf_pkg::SUM_W'(drop);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
      end else if (ctl.step) begin
         sum_ff <= sum_in;
      end
   end

   assign sum_next = sum_in;

endmodule
`default_nettype wire

FILE: sv/bbrf_out.sv
`timescale 1ns / 1ps
`default_nettype none
module bbrf_out (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           load,
   input  wire bbrf_pkg::emit_type             emit,
   input  wire logic      [bbrf_pkg::RAD_W-1:0] radius,
   output logic                                ready,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic           [bbrf_pkg::PIX_W-1:0] rsp_pixel_out,
   output logic                                rsp_last_in_row,
   output logic                                rsp_last_in_frame
);

   logic                          s1_valid_ff;
   logic                          s1_valid_in;
   bbrf_pkg::emit_type            s1_ff;
   logic                          out_valid_ff;
   logic                          out_valid_in;
   logic [bbrf_pkg::PIX_W-1:0]    out_pix_ff;
   logic                          out_row_ff;
   logic                          out_frame_ff;
   logic                          advance;
   logic [bbrf_pkg::PROD_W-1:0]   product;
   logic [bbrf_pkg::PIX_W-1:0]    quot;

   assign advance = !out_valid_ff || !rsp_stall;
   assign ready   = !s1_valid_ff || advance;

   // multiply by reciprocal of the window span
   assign product = bbrf_pkg::PROD_W'(s1_ff.sum) * bbrf_pkg::PROD_W'(bbrf_pkg::recip_of(radius));
   assign quot    = product[bbrf_pkg::RECIP_SHIFT +: bbrf_pkg::PIX_W];

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (load) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
      out_valid_in = advance ? s1_valid_ff : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         s1_ff <= emit;
      end
      if (advance && s1_valid_ff) begin
         out_pix_ff   <= quot;
         out_row_ff   <= s1_ff.last_row;
         out_frame_ff <= s1_ff.last_frame;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_pixel_out     = out_pix_ff;
   assign rsp_last_in_row   = out_row_ff;
   assign rsp_last_in_frame = out_frame_ff;

endmodule
`default_nettype wire

FILE: sv/box_blur_row_filter.sv
// Horizontal box blur over a pixel stream, edge pixels replicated.
// Input transactions (req_valid/req_stall) carry one 8-bit pixel each, rows
// in order left to right. Output transactions (rsp_valid/rsp_stall) carry the
// blurred pixel with end-of-row and end-of-frame flags.
// One pixel is taken per cycle while req_stall is low. After the last pixel of a row
// the window of cells is stepped radius more times with the replicated edge pixel,
// and req_stall stays high meanwhile.
// Output k of a row is held in the internal stage as a running sum after the window
// step that completes it, then leaves the output register after the reciprocal multiply.
// The first radius pixels of a row produce no transaction.
// When rsp_stall holds a result, one more result may wait in the internal
// stage; after that req_stall rises until the output side moves again.
// Config writes (csr_valid/csr_ready, index 0 radius, 1 row width, 2 row count)
// are always accepted and restart the frame; write only while idle.
// Synchronous reset: radius 1, row width 640, row count 480, frame restarted,
// no results pending. Window cells are not reset; each row refills them.
`timescale 1ns / 1ps
`default_nettype none
module box_blur_row_filter (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic        [bbrf_pkg::PIX_W-1:0] req_pixel,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic             [bbrf_pkg::PIX_W-1:0] rsp_pixel_out,
   output logic                                  rsp_last_in_row,
   output logic                                  rsp_last_in_frame,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic    [bbrf_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic        [bbrf_pkg::REG_W-1:0] csr_data
);

   logic [bbrf_pkg::RAD_W-1:0] radius_ff;
   logic [bbrf_pkg::REG_W-1:0] width_ff;
   logic [bbrf_pkg::REG_W-1:0] rows_ff;
   logic [bbrf_pkg::COL_W-1:0] column_ff;
   logic [bbrf_pkg::COL_W-1:0] column_in;
   logic [bbrf_pkg::ROW_W-1:0] row_ff;
   logic [bbrf_pkg::ROW_W-1:0] row_in;
   logic                       tail_busy_ff;
   logic                       tail_busy_in;
   logic [bbrf_pkg::RAD_W-1:0] tail_m_ff;
   logic [bbrf_pkg::RAD_W-1:0] tail_m_in;
   logic [bbrf_pkg::COL_W-1:0] tail_col_ff;
   logic [bbrf_pkg::PIX_W-1:0] tail_px_ff;
   logic                       tail_fe_ff;

   logic [bbrf_pkg::REG_W-1:0] width_eff;
   logic [bbrf_pkg::REG_W-1:0] rows_eff;
   logic                       stage_ready;
   logic                       take;
   logic                       tail_step;
   logic                       col_final;
   logic                       frame_end;
   logic                       do_emit;
   logic                       csr_write;
   bbrf_pkg::win_ctl_type      win_ctl;
   bbrf_pkg::emit_type         emit;
   logic [bbrf_pkg::SUM_W-1:0] sum_next;

   always_comb begin
      if (width_ff == '0) begin
         width_eff = bbrf_pkg::REG_W'(1);
      end else if (width_ff > bbrf_pkg::REG_W'(bbrf_pkg::MAX_WIDTH)) begin
         width_eff = bbrf_pkg::REG_W'(bbrf_pkg::MAX_WIDTH);
      end else begin
         width_eff = width_ff;
      end
      if (rows_ff == '0) begin
         rows_eff = bbrf_pkg::REG_W'(1);
      end else if (rows_ff > bbrf_pkg::REG_W'(bbrf_pkg::ROWS_LIMIT)) begin
         rows_eff = bbrf_pkg::REG_W'(bbrf_pkg::ROWS_LIMIT);
      end else begin
         rows_eff = rows_ff;
      end
   end

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;
   assign req_stall = tail_busy_ff || !stage_ready;
   assign take      = req_valid && !req_stall;
   assign tail_step = tail_busy_ff && stage_ready;
   assign col_final = ({1'b0, column_ff} + bbrf_pkg::REG_W'(1)) >= width_eff;
   assign frame_end = ({1'b0, row_ff} + bbrf_pkg::REG_W'(1)) >= rows_eff;

   always_comb begin
      win_ctl.step = take || tail_step;
      win_ctl.fill = take && (column_ff == '0);
      win_ctl.px   = tail_busy_ff ? tail_px_ff : req_pixel;
      emit.sum     = sum_next;
      if (tail_busy_ff) begin
         do_emit         = ({1'b0, tail_col_ff} + bbrf_pkg::REG_W'(tail_m_ff))
                           >= bbrf_pkg::REG_W'(radius_ff);
         emit.last_row   = tail_m_ff == radius_ff;
         emit.last_frame = (tail_m_ff == radius_ff) && tail_fe_ff;
      end else begin
         do_emit         = column_ff >= bbrf_pkg::COL_W'(radius_ff);
         emit.last_row   = col_final && (radius_ff == '0);
         emit.last_frame = col_final && (radius_ff == '0) && frame_end;
      end
   end

   always_comb begin
      column_in    = column_ff;
      row_in       = row_ff;
      tail_busy_in = tail_busy_ff;
      tail_m_in    = tail_m_ff;
      if (tail_step) begin
         tail_m_in = tail_m_ff + bbrf_pkg::RAD_W'(1);
         if (tail_m_ff == radius_ff) begin
            tail_busy_in = 1'b0;
         end
      end
      if (take) begin
         if (col_final) begin
            column_in = '0;
            row_in    = frame_end ? '0 : row_ff + bbrf_pkg::ROW_W'(1);
            if (radius_ff != '0) begin
               tail_busy_in = 1'b1;
               tail_m_in    = bbrf_pkg::RAD_W'(1);
            end
         end else begin
            column_in = column_ff + bbrf_pkg::COL_W'(1);
         end
      end
      if (csr_write && (csr_index == bbrf_pkg::CSR_RADIUS
                        || csr_index == bbrf_pkg::CSR_ROW_WIDTH
                        || csr_index == bbrf_pkg::CSR_ROW_COUNT)) begin
         column_in = '0;
         row_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff    <= bbrf_pkg::RADIUS_RESET;
         width_ff     <= bbrf_pkg::ROW_WIDTH_RESET;
         rows_ff      <= bbrf_pkg::ROW_COUNT_RESET;
         column_ff    <= '0;
         row_ff       <= '0;
         tail_busy_ff <= 1'b0;
         tail_m_ff    <= '0;
      end else begin
         column_ff    <= column_in;
         row_ff       <= row_in;
         tail_busy_ff <= tail_busy_in;
         tail_m_ff    <= tail_m_in;
         if (csr_write) begin
            case (csr_index)
               bbrf_pkg::CSR_RADIUS:    radius_ff <= csr_data[bbrf_pkg::RAD_W-1:0];
               bbrf_pkg::CSR_ROW_WIDTH: width_ff  <= csr_data;
               bbrf_pkg::CSR_ROW_COUNT: rows_ff   <= csr_data;
               default: ;
            endcase
         end
      end
   end

   // edge pixel and row position kept for the end-of-row flush
   always_ff @(posedge clock) begin
      if (take && col_final) begin
         tail_col_ff <= column_ff;
         tail_px_ff  <= req_pixel;
         tail_fe_ff  <= frame_end;
      end
   end

   bbrf_window u_window (
      .clock    (clock),
      .reset    (reset),
      .ctl      (win_ctl),
      .radius   (radius_ff),
      .sum_next (sum_next)
   );

   bbrf_out u_out (
      .clock             (clock),
      .reset             (reset),
      .load              (win_ctl.step && do_emit),
      .emit              (emit),
      .radius            (radius_ff),
      .ready             (stage_ready),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_pixel_out     (rsp_pixel_out),
      .rsp_last_in_row   (rsp_last_in_row),
      .rsp_last_in_frame (rsp_last_in_frame)
   );

endmodule
`default_nettype wire

FILE: test/tb_top.sv
`timescale 1ns / 1ps
module tb_top;

   localparam int RANDOM_ITEMS   = 320;
   localparam int HOLD_CYCLES    = 300;
   localparam int DRAIN_CYCLES   = 2 * bbrf_pkg::MAX_RADIUS + 10;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam logic [bbrf_pkg::CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   typedef enum {FLOW_FREE, FLOW_COIN, FLOW_TOGGLE, FLOW_CHOKE} flow_mode_type;
   typedef enum {PX_RANDOM, PX_EXTREME, PX_FLAT} px_mode_type;

   typedef struct packed {
      logic [bbrf_pkg::PIX_W-1:0] pixel;
      logic                       last_row;
      logic                       last_frame;
   } blur_px_type;

   class blur_scoreboard;
      logic [bbrf_pkg::PIX_W-1:0] win [bbrf_pkg::WIN_DEPTH];
      int unsigned                win_sum;
      int unsigned                col;
      int unsigned                row_idx;
      logic [bbrf_pkg::RAD_W-1:0] radius;
      logic [bbrf_pkg::REG_W-1:0] row_width;
      logic [bbrf_pkg::REG_W-1:0] row_count;
      blur_px_type                owed [$];
      int                         errors;

      function new();
         radius    = bbrf_pkg::RADIUS_RESET;
         row_width = bbrf_pkg::ROW_WIDTH_RESET;
         row_count = bbrf_pkg::ROW_COUNT_RESET;
         win_sum   = 0;
         col       = 0;
         row_idx   = 0;
         errors    = 0;
         foreach (win[i]) win[i] = '0;
      endfunction

      function int unsigned eff_radius();
         return (radius > bbrf_pkg::MAX_RADIUS) ? bbrf_pkg::MAX_RADIUS : radius;
      endfunction

      function int unsigned eff_width();
         if (row_width == 0) return 1;
         return (row_width > bbrf_pkg::MAX_WIDTH) ? bbrf_pkg::MAX_WIDTH : row_width;
      endfunction

      function int unsigned eff_rows();
         if (row_count == 0) return 1;
         return (row_count > bbrf_pkg::ROWS_LIMIT) ? bbrf_pkg::ROWS_LIMIT : row_count;
      endfunction

      function void write_reg(logic [bbrf_pkg::CSR_IDX_W-1:0] idx,
                              logic [bbrf_pkg::REG_W-1:0] val);
         case (idx)
            bbrf_pkg::CSR_RADIUS:    radius = val[bbrf_pkg::RAD_W-1:0];
            bbrf_pkg::CSR_ROW_WIDTH: row_width = val;
            bbrf_pkg::CSR_ROW_COUNT: row_count = val;
            default:                 return;
         endcase
         col     = 0;
         row_idx = 0;
      endfunction

      function void shift_window(logic [bbrf_pkg::PIX_W-1:0] px, int unsigned span);
         logic [bbrf_pkg::PIX_W-1:0] dropped;
         dropped = win[span-1];
         for (int i = span - 1; i > 0; i--) win[i] = win[i-1];
         win[0]  = px;
         win_sum = win_sum + px - dropped;
      endfunction

      function void push_average(int unsigned span, bit last_row, bit frame_end);
         blur_px_type o;
         o.pixel      = bbrf_pkg::PIX_W'(win_sum / span);
         o.last_row   = last_row;
         o.last_frame = last_row && frame_end;
         owed.push_back(o);
      endfunction

      function void take_pixel(logic [bbrf_pkg::PIX_W-1:0] px);
         int unsigned r;
         int unsigned span;
         bit          last_col;
         bit          frame_end;
         r         = eff_radius();
         span      = 2 * r + 1;
         last_col  = (col + 1 >= eff_width());
         frame_end = (row_idx + 1 >= eff_rows());
         if (col == 0) begin
            for (int i = 0; i < span; i++) win[i] = px;
            win_sum = span * px;
         end else begin
            shift_window(px, span);
         end
         if (col >= r) push_average(span, last_col && r == 0, frame_end);
         if (last_col) begin
            for (int m = 1; m <= r; m++) begin
               shift_window(px, span);
               if (col + m >= r) push_average(span, m == r, frame_end);
            end
            col     = 0;
            row_idx = frame_end ? 0 : row_idx + 1;
         end else begin
            col = col + 1;
         end
      endfunction

      function void check_output(logic [bbrf_pkg::PIX_W-1:0] pix, logic lr, logic lf);
         blur_px_type want;
         if (owed.size() == 0) begin
            errors++;
            $error("unexpected output transaction: pixel_out %0d", pix);
            return;
         end
         want = owed.pop_front();
         if (pix !== want.pixel) begin
            errors++;
            $error("pixel_out: expected %0d, got %0d", want.pixel, pix);
         end
         if (lr !== want.last_row) begin
            errors++;
            $error("last_in_row: expected %0b, got %0b", want.last_row, lr);
         end
         if (lf !== want.last_frame) begin
            errors++;
            $error("last_in_frame: expected %0b, got %0b", want.last_frame, lf);
         end
      endfunction
   endclass

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_stall;
   logic [bbrf_pkg::PIX_W-1:0]     req_pixel = '0;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   logic [bbrf_pkg::PIX_W-1:0]     rsp_pixel_out;
   logic                           rsp_last_in_row;
   logic                           rsp_last_in_frame;
   logic                           csr_valid = 1'b0;
   logic                           csr_ready;
   logic [bbrf_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [bbrf_pkg::REG_W-1:0]     csr_data = '0;

   logic          hold_go = 1'b0;
   int            hold_left = 0;
   bit            hold_done = 1'b0;
   int            mode_left = 0;
   flow_mode_type flow_mode = FLOW_FREE;
   int            idle_cycles = 0;
   int            burst_left = 0;
   bit            gaps_on = 1'b0;

   blur_scoreboard sb = new;

   box_blur_row_filter i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_pixel         (req_pixel),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_pixel_out     (rsp_pixel_out),
      .rsp_last_in_row   (rsp_last_in_row),
      .rsp_last_in_frame (rsp_last_in_frame),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_output(rsp_pixel_out, rsp_last_in_row, rsp_last_in_frame);
   end

   always @(posedge clock) begin
      if (hold_go && !hold_done) begin
         hold_left = HOLD_CYCLES;
         hold_done = 1'b1;
      end
      if (mode_left == 0) begin
         flow_mode = flow_mode_type'($urandom_range(0, 3));
         mode_left = $urandom_range(20, 80);
      end else begin
         mode_left--;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         case (flow_mode)
            FLOW_FREE:   rsp_stall <= 1'b0;
            FLOW_COIN:   rsp_stall <= 1'($urandom_range(0, 1));
            FLOW_TOGGLE: rsp_stall <= ~rsp_stall;
            default:     rsp_stall <= ($urandom_range(0, 3) != 0);
         endcase
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin
      wait (idle_cycles >= WATCHDOG_LIMIT);
      $display("TB_ERROR");
      $finish;
   end

   task automatic send_pixel(input logic [bbrf_pkg::PIX_W-1:0] px);
      if (gaps_on && burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         if ($urandom_range(0, 2) != 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_pixel <= px;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.take_pixel(px);
      if (burst_left > 0) burst_left--;
   endtask

   task automatic write_reg(input logic [bbrf_pkg::CSR_IDX_W-1:0] idx,
                            input logic [bbrf_pkg::REG_W-1:0] val,
                            input bit more);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.write_reg(idx, val);
      if (!more) csr_valid <= 1'b0;
   endtask

   // wait for all owed outputs, then let the pipeline empty
   task automatic settle();
      req_valid <= 1'b0;
      while (sb.owed.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic feed_pixels(input int npix, input px_mode_type pmode);
      logic [bbrf_pkg::PIX_W-1:0] flat;
      flat = bbrf_pkg::PIX_W'($urandom);
      for (int i = 0; i < npix; i++) begin
         case (pmode)
            PX_EXTREME: send_pixel($urandom_range(0, 1) ? 8'hff : 8'h00);
            PX_FLAT:    send_pixel(flat);
            default:    send_pixel(bbrf_pkg::PIX_W'($urandom));
         endcase
      end
   endtask

   initial begin
      int unsigned                r;
      int unsigned                w;
      int unsigned                rows;
      int unsigned                frame;
      int                         npix;
      int                         random_items;
      int                         phase;
      px_mode_type                pmode;
      logic [bbrf_pkg::REG_W-1:0] rad_data;

      random_items = 0;
      phase        = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings, mid-row outputs only
      send_pixel(8'h00);
      send_pixel(8'hff);
      send_pixel(8'hff);
      send_pixel(8'h00);
      settle();

      // radius 0, zero width and zero rows: every pixel ends a frame
      write_reg(bbrf_pkg::CSR_RADIUS, 13'h1ff0, 1'b1);
      write_reg(bbrf_pkg::CSR_ROW_WIDTH, 13'd0, 1'b1);
      write_reg(bbrf_pkg::CSR_ROW_COUNT, 13'd0, 1'b0);
      send_pixel(8'hff);
      send_pixel(8'h00);
      send_pixel(8'h01);
      settle();

      // narrow rows, unused index mid-row must not restart the frame
      write_reg(bbrf_pkg::CSR_RADIUS, 13'd2, 1'b1);
      write_reg(bbrf_pkg::CSR_ROW_WIDTH, 13'd3, 1'b1);
      write_reg(bbrf_pkg::CSR_ROW_COUNT, 13'd2, 1'b0);
      send_pixel(8'h00);
      send_pixel(8'hff);
      settle();
      write_reg(CSR_UNUSED, 13'h1fff, 1'b0);
      send_pixel(8'hff);
      send_pixel(8'hff);
      send_pixel(8'hff);
      send_pixel(8'h00);

      while (random_items < RANDOM_ITEMS) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: r = $urandom_range(0, 3);
            6, 7:             r = $urandom_range(4, 14);
            default:          r = bbrf_pkg::MAX_RADIUS;
         endcase
         case ($urandom_range(0, 9))
            0:       w = $urandom_range(0, 2 * r);
            1:       w = $urandom_range(0, 1) ? $urandom_range(4096, 8191) : 8191;
            default: w = $urandom_range(2 * r + 1, 2 * r + 24);
         endcase
         case ($urandom_range(0, 9))
            0:       rows = 0;
            1:       rows = $urandom_range(0, 1) ? 4096 : 8191;
            default: rows = $urandom_range(1, 4);
         endcase
         case (phase)
            0: begin
               r = bbrf_pkg::MAX_RADIUS;
               w = 8191;
               rows = 4096;
            end
            1: begin
               r = bbrf_pkg::MAX_RADIUS;
               w = 40;
               rows = 1;
            end
            2: begin
               r = 2;
               w = 24;
               rows = 3;
            end
            default: ;
         endcase

         settle();
         rad_data = bbrf_pkg::REG_W'($urandom);
         rad_data[bbrf_pkg::RAD_W-1:0] = bbrf_pkg::RAD_W'(r);
         write_reg(bbrf_pkg::CSR_RADIUS, rad_data, 1'b1);
         write_reg(bbrf_pkg::CSR_ROW_WIDTH, bbrf_pkg::REG_W'(w), 1'b1);
         write_reg(bbrf_pkg::CSR_ROW_COUNT, bbrf_pkg::REG_W'(rows), 1'b0);

         frame = sb.eff_width() * sb.eff_rows();
         if (frame <= 96) begin
            npix = frame * (($urandom_range(0, 3) == 0) ? 2 : 1);
            if ($urandom_range(0, 4) == 0) npix = $urandom_range(1, npix);
         end else begin
            npix = $urandom_range(r + 1, r + 40);
         end
         case ($urandom_range(0, 5))
            0:       pmode = PX_EXTREME;
            1:       pmode = PX_FLAT;
            default: pmode = PX_RANDOM;
         endcase
         gaps_on    = ($urandom_range(0, 2) != 0);
         burst_left = 0;

         // long output hold while the input keeps coming
         if (phase == 2) begin
            npix    = frame;
            pmode   = PX_RANDOM;
            gaps_on = 1'b0;
            hold_go <= 1'b1;
         end

         if (npix > RANDOM_ITEMS - random_items) npix = RANDOM_ITEMS - random_items;

         feed_pixels(npix, pmode);
         random_items += npix;
         phase++;
      end

      settle();
      if (sb.errors == 0 && sb.owed.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
